// ----- rtl/nonuniform_linear_basis_eval_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nonuniform linear basis evaluator
// Clocked implication helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef NONUNIFORM_LINEAR_BASIS_EVAL_ASSERT_SVH
`define NONUNIFORM_LINEAR_BASIS_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define NLBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("nlbe assertion failed");

// Next-cycle implication, disabled while reset is low
`define NLBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("nlbe assertion failed");

`endif

// ----- rtl/nlbe_pkg.sv -----
// ----------------------------------------------------------------------------
// nlbe_pkg
// Shared types, codes and constants of the nonuniform linear basis evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package nlbe_pkg;

	localparam int FRACTION_BITS    = 16;
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int QUEUE_DEPTH      = 8;
	localparam int WEIGHT_W         = FRACTION_BITS + 1;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_ELEMENT_COUNT   = 2'd0;
	localparam logic [1:0] CFG_DOMAIN_LENGTH   = 2'd1;
	localparam logic [1:0] CFG_INVERSE_SPACING = 2'd2;

	// Register reset values
	localparam logic [10:0] ELEMENT_COUNT_RST   = 11'd1024;
	localparam logic [30:0] DOMAIN_LENGTH_RST   = 31'd65536;
	localparam logic [31:0] INVERSE_SPACING_RST = 32'd67108864;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [31:0]         GRAD_MAX   = 32'h7FFF_FFFF;

	typedef struct packed {
		logic               command;
		logic [9:0]         node_index;
		logic [30:0]        node_position;
		logic signed [31:0] point_position;
	} nlbe_item_t;

	typedef struct packed {
		logic [10:0]        node_id;
		logic [16:0]        weight;
		logic signed [31:0] gradient;
		logic               out_of_domain;
		logic               last;
	} nlbe_result_t;

	// Classified evaluate command handed from front to back
	typedef struct packed {
		logic        ood;
		logic [10:0] elem;
		logic [30:0] point;
		logic [30:0] left;
		logic [30:0] right;
	} nlbe_entry_t;

endpackage

`default_nettype wire

// ----- rtl/nlbe_front.sv -----
// ----------------------------------------------------------------------------
// nlbe_front
// Accepts commands, holds the configuration and the banked node store,
// guesses and corrects the element and pushes classified evaluates.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbe_front #(
	parameter int MAX_ELEMENTS = nlbe_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        cfg_write,
	input  wire logic [1:0]                                  cfg_index,
	input  wire logic [31:0]                                 cfg_data,
	input  wire logic                                        item_valid,
	output logic                                             item_ready,
	input  wire nlbe_pkg::nlbe_item_t                        item,
	input  wire logic [$clog2(nlbe_pkg::QUEUE_DEPTH+1)-1:0]  queue_count,
	output logic                                             push,
	output nlbe_pkg::nlbe_entry_t                            push_entry
);
	import nlbe_pkg::*;

	localparam int N_W    = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W  = $clog2(MAX_ELEMENTS + 2);
	localparam int BANK_D = (MAX_ELEMENTS + 3) / 4;
	localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int G_W    = 63 - 2 * FRACTION_BITS;

	logic [10:0] elem_count_q;
	logic [30:0] domain_q;
	logic [31:0] inv_q;
	logic [N_W-1:0] n_act;

	logic        accept;
	logic        v_s1, v_s2, v_s3;
	logic        cmd_s1, cmd_s2, cmd_s3;
	logic [9:0]  nidx_s1, nidx_s2;
	logic [30:0] npos_s1, npos_s2;
	logic [31:0] point_s1;
	logic [30:0] p_s2, p_s3;
	logic        ood_s2, ood_s3;
	logic [62:0] prod_s2;

	logic            ood_c;
	logic [62:0]     mul_c;
	logic [G_W-1:0]  guess;
	logic [N_W-1:0]  nm1;
	logic [IDX_W-1:0] e_c, m_c;
	logic [BA_W-1:0] raddr [4];
	logic [3:0]      zero_c, high_c;
	logic [IDX_W-1:0] e_s3;
	logic [1:0]      lo2_s3;
	logic [3:0]      zero_s3, high_s3;
	logic [30:0]     rd_s3 [4];
	logic [30:0]     nv [4];
	logic            wr_en;
	logic [BA_W-1:0] waddr;
	logic [CNT_W:0]  used;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_count_q <= ELEMENT_COUNT_RST;
			domain_q     <= DOMAIN_LENGTH_RST;
			inv_q        <= INVERSE_SPACING_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ELEMENT_COUNT:   elem_count_q <= cfg_data[10:0];
				CFG_DOMAIN_LENGTH:   domain_q     <= cfg_data[30:0];
				CFG_INVERSE_SPACING: inv_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the element count into 1 .. MAX_ELEMENTS
	always_comb begin
		if (elem_count_q == '0) begin
			n_act = N_W'(1);
		end else if (32'(elem_count_q) > 32'(MAX_ELEMENTS)) begin
			n_act = N_W'(MAX_ELEMENTS);
		end else begin
			n_act = N_W'(elem_count_q);
		end
	end

	// Admit a beat only when the queue has room for everything in flight
	assign used = {1'b0, queue_count} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2)
		+ (CNT_W+1)'(v_s3);
	assign item_ready = used < (CNT_W+1)'(QUEUE_DEPTH);
	assign accept = item_valid && item_ready;

	// Valid bits of the front pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: domain check and element guess product
	assign ood_c = point_s1[31] || (point_s1[30:0] > domain_q);
	assign mul_c = 63'(point_s1[30:0]) * 63'(inv_q);

	// Stage 2: clamp the guess, address the four banks for nodes e-1 .. e+2
	assign guess = prod_s2[62:2*FRACTION_BITS];
	assign nm1   = n_act - N_W'(1);

	always_comb begin
		logic [1:0]       off;
		logic [IDX_W-1:0] ridx;
		if (32'(guess) >= 32'(nm1)) begin
			e_c = IDX_W'(nm1);
		end else begin
			e_c = IDX_W'(guess);
		end
		m_c = e_c - IDX_W'(1);
		for (int b = 0; b < 4; b++) begin
			off      = 2'(b) - m_c[1:0];
			ridx     = m_c + IDX_W'(off);
			raddr[b] = BA_W'(ridx >> 2);
		end
		for (int k = 0; k < 4; k++) begin
			ridx      = m_c + IDX_W'(k);
			zero_c[k] = (ridx == '0);
			high_c[k] = 32'(ridx) >= 32'(n_act);
		end
	end

	assign wr_en = v_s2 && (cmd_s2 == CMD_WRITE) && (nidx_s2 != '0)
		&& (32'(nidx_s2) < 32'(MAX_ELEMENTS));
	assign waddr = BA_W'(nidx_s2 >> 2);

	// Pipe payload
	always_ff @(posedge clk) begin
		cmd_s1   <= item.command;
		nidx_s1  <= item.node_index;
		npos_s1  <= item.node_position;
		point_s1 <= item.point_position;

		cmd_s2  <= cmd_s1;
		nidx_s2 <= nidx_s1;
		npos_s2 <= npos_s1;
		p_s2    <= point_s1[30:0];
		ood_s2  <= ood_c;
		prod_s2 <= mul_c;

		cmd_s3  <= cmd_s2;
		p_s3    <= p_s2;
		ood_s3  <= ood_s2;
		e_s3    <= e_c;
		lo2_s3  <= m_c[1:0];
		zero_s3 <= zero_c;
		high_s3 <= high_c;
	end

	// Node store: four banks by index modulo four, one read and one write each
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [30:0] mem [BANK_D];
		always_ff @(posedge clk) begin
			if (wr_en && (nidx_s2[1:0] == 2'(b))) begin
				mem[waddr] <= npos_s2;
			end
			if (v_s2) begin
				rd_s3[b] <= mem[raddr[b]];
			end
		end
	end

	// Stage 3: resolve node values and correct the element by one
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (zero_s3[k]) begin
				nv[k] = '0;
			end else if (high_s3[k]) begin
				nv[k] = domain_q;
			end else begin
				nv[k] = rd_s3[2'(lo2_s3 + 2'(k))];
			end
		end
		push_entry.ood   = ood_s3;
		push_entry.point = p_s3;
		if (!high_s3[2] && (p_s3 >= nv[2])) begin
			push_entry.elem  = 11'(e_s3 + IDX_W'(1));
			push_entry.left  = nv[2];
			push_entry.right = nv[3];
		end else if ((p_s3 < nv[1]) && (e_s3 != '0)) begin
			push_entry.elem  = 11'(e_s3 - IDX_W'(1));
			push_entry.left  = nv[0];
			push_entry.right = nv[1];
		end else begin
			push_entry.elem  = 11'(e_s3);
			push_entry.left  = nv[1];
			push_entry.right = nv[2];
		end
	end

	assign push = v_s3 && (cmd_s3 == CMD_EVAL);

endmodule

`default_nettype wire

// ----- rtl/nlbe_queue.sv -----
// ----------------------------------------------------------------------------
// nlbe_queue
// Short FIFO that decouples the classifying front from the dividing back.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbe_queue (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        push,
	input  wire nlbe_pkg::nlbe_entry_t                       push_entry,
	input  wire logic                                        pop,
	output nlbe_pkg::nlbe_entry_t                            pop_entry,
	output logic                                             not_empty,
	output logic [$clog2(nlbe_pkg::QUEUE_DEPTH+1)-1:0]       count
);
	import nlbe_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	nlbe_entry_t      ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign pop_entry = ent_q[rp_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

`default_nettype wire

// ----- rtl/nlbe_back.sv -----
// ----------------------------------------------------------------------------
// nlbe_back
// Pipelined restoring dividers for weight and gradient; the output register
// emits left and right node of each element, or one out-of-domain beat.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbe_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   queue_valid,
	input  wire nlbe_pkg::nlbe_entry_t  entry,
	output logic                        pop,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output nlbe_pkg::nlbe_result_t      result
);
	import nlbe_pkg::*;

	localparam int STEPS = 2 * FRACTION_BITS;

	typedef struct packed {
		logic                     ood;
		logic [10:0]              elem;
		logic                     hpos;
		logic                     wz;
		logic                     wo;
		logic [30:0]              h;
		logic [30:0]              rg;
		logic [STEPS-1:0]         qg;
		logic [30:0]              rw;
		logic [FRACTION_BITS-1:0] qw;
	} div_t;

	div_t       div_s [STEPS+1];
	div_t       nxt   [STEPS+1];
	logic [STEPS:0] dv_s;
	logic       adv;

	logic                out_valid_q, phase_q, ood_q;
	logic [10:0]         elem_q;
	logic [WEIGHT_W-1:0] wl_q, wr_q;
	logic [31:0]         g_q;
	logic [WEIGHT_W-1:0] wr_c;
	logic [31:0]         g_c;

	// Whole back pipe moves when the output register frees up
	assign adv = !out_valid_q || (result_ready && (phase_q || ood_q));
	assign pop = adv && queue_valid;

	// Entry setup and one quotient bit per stage
	always_comb begin
		logic [31:0] h32, d32, tg, tw;
		h32 = {1'b0, entry.right} - {1'b0, entry.left};
		d32 = {1'b0, entry.point} - {1'b0, entry.left};
		nxt[0].ood  = entry.ood;
		nxt[0].elem = entry.elem;
		nxt[0].hpos = !h32[31] && (h32 != '0);
		nxt[0].wz   = d32[31] || (d32 == '0);
		nxt[0].wo   = !d32[31] && (d32 >= h32);
		nxt[0].h    = h32[30:0];
		nxt[0].rg   = 31'd1;
		nxt[0].qg   = '0;
		nxt[0].rw   = d32[30:0];
		nxt[0].qw   = '0;
		for (int k = 0; k < STEPS; k++) begin
			nxt[k+1] = div_s[k];
			tg = {div_s[k].rg, 1'b0};
			if (tg >= {1'b0, div_s[k].h}) begin
				nxt[k+1].rg = 31'(tg - {1'b0, div_s[k].h});
				nxt[k+1].qg = {div_s[k].qg[STEPS-2:0], 1'b1};
			end else begin
				nxt[k+1].rg = tg[30:0];
				nxt[k+1].qg = {div_s[k].qg[STEPS-2:0], 1'b0};
			end
			if (k < FRACTION_BITS) begin
				tw = {div_s[k].rw, 1'b0};
				if (tw >= {1'b0, div_s[k].h}) begin
					nxt[k+1].rw = 31'(tw - {1'b0, div_s[k].h});
					nxt[k+1].qw = {div_s[k].qw[FRACTION_BITS-2:0], 1'b1};
				end else begin
					nxt[k+1].rw = tw[30:0];
					nxt[k+1].qw = {div_s[k].qw[FRACTION_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Divider stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= STEPS; k++) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	// Divider stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
		end else if (adv) begin
			dv_s <= {dv_s[STEPS-1:0], queue_valid};
		end
	end

	// Saturate the gradient and clamp the right weight
	always_comb begin
		if (!div_s[STEPS].hpos) begin
			g_c  = '0;
			wr_c = '0;
		end else begin
			if (64'(div_s[STEPS].qg) > 64'(GRAD_MAX)) begin
				g_c = GRAD_MAX;
			end else begin
				g_c = 32'(div_s[STEPS].qg);
			end
			if (div_s[STEPS].wz) begin
				wr_c = '0;
			end else if (div_s[STEPS].wo) begin
				wr_c = WEIGHT_ONE;
			end else begin
				wr_c = {1'b0, div_s[STEPS].qw};
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ood_q  <= div_s[STEPS].ood;
			elem_q <= div_s[STEPS].elem;
			wr_q   <= wr_c;
			wl_q   <= WEIGHT_ONE - wr_c;
			g_q    <= g_c;
		end
	end

	// Output valid and beat phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_s[STEPS];
			phase_q     <= 1'b0;
		end else if (result_ready) begin
			phase_q <= 1'b1;
		end
	end

	// Drive the left beat, then the right beat, or a lone out-of-domain beat
	always_comb begin
		result_valid = out_valid_q;
		if (ood_q) begin
			result.node_id       = '0;
			result.weight        = '0;
			result.gradient      = '0;
			result.out_of_domain = 1'b1;
			result.last          = 1'b1;
		end else if (!phase_q) begin
			result.node_id       = elem_q;
			result.weight        = wl_q;
			result.gradient      = 32'd0 - g_q;
			result.out_of_domain = 1'b0;
			result.last          = 1'b0;
		end else begin
			result.node_id       = elem_q + 11'd1;
			result.weight        = wr_q;
			result.gradient      = g_q;
			result.out_of_domain = 1'b0;
			result.last          = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nonuniform_linear_basis_eval.sv -----
// ----------------------------------------------------------------------------
// nonuniform_linear_basis_eval: front pipe, queue, divider pipe, then the output register.
// Throughput: writes and out-of-domain points one per cycle unless the queue or output stalls;
// in-domain evaluates are held to the pace of their two result beats on the single output channel.
// Output: two beats per in-domain evaluate, one beat for out of domain, none for writes.
// Reset sets the registers to defaults; node store is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nonuniform_linear_basis_eval #(
	parameter int MAX_ELEMENTS = nlbe_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [31:0]           cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire nlbe_pkg::nlbe_item_t  item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output nlbe_pkg::nlbe_result_t     result
);
	import nlbe_pkg::*;

	logic                               push, pop, not_empty;
	nlbe_entry_t                        push_entry, pop_entry;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count;

	nlbe_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_count(queue_count),
		.push       (push),
		.push_entry (push_entry)
	);

	nlbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.not_empty (not_empty),
		.count     (queue_count)
	);

	nlbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (not_empty),
		.entry       (pop_entry),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

`default_nettype wire

// ----- rtl/nlbe_checker.sv -----
// ----------------------------------------------------------------------------
// nlbe_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nonuniform_linear_basis_eval_assert.svh"

module nlbe_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   result_valid,
	input wire logic                   result_ready,
	input wire nlbe_pkg::nlbe_result_t result
);
	import nlbe_pkg::*;

	// Hold a stalled beat
	`NLBE_ASSERT_NXT(a_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// Out-of-domain beat is a lone, zeroed, final beat
	`NLBE_ASSERT_IMP(a_ood, clk, arst_n, result_valid && result.out_of_domain, result.last && (result.node_id == '0) && (result.weight == '0) && (result.gradient == '0))

	// Right beat follows left beat at the next node with weights summing to one
	`NLBE_ASSERT_NXT(a_pair, clk, arst_n, result_valid && result_ready && !result.last, result_valid && result.last && (result.node_id == 11'($past(result.node_id) + 11'd1)) && (17'(result.weight + $past(result.weight)) == WEIGHT_ONE))

	// Weights never exceed one
	`NLBE_ASSERT_IMP(a_wmax, clk, arst_n, result_valid, result.weight <= WEIGHT_ONE)

endmodule

bind nonuniform_linear_basis_eval nlbe_checker u_nlbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

`default_nettype wire

// ----- verif/tb_nonuniform_linear_basis_eval.sv -----
// ----------------------------------------------------------------------------
// tb_nonuniform_linear_basis_eval
// Self-checking bench for the non-uniform grid hat basis evaluator. It loads
// ordered node sets for several register settings and runs directed and
// random write/evaluate beats. Each result beat is matched against an
// in-bench Q16.16 predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nonuniform_linear_basis_eval;
	import nlbe_pkg::*;

	localparam int NPHASE      = 7;
	localparam int RAND_ITEMS  = 70;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN       = 60;

	logic         clk;
	logic         arst_n;
	logic         cfg_write;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         item_valid;
	logic         item_ready;
	nlbe_item_t   item;
	logic         result_valid;
	logic         result_ready;
	nlbe_result_t result;

	nonuniform_linear_basis_eval u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// Predictor state
	logic [30:0]  node_pos [1024];
	logic [10:0]  elem_count_reg;
	logic [30:0]  domain_len_reg;
	logic [31:0]  inv_spacing_reg;
	nlbe_result_t basis_q [$];

	bit failed;
	int stall_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic longint node_at(int unsigned idx, int unsigned n);
		if (idx == 0) return 0;
		if (idx >= n) return longint'(domain_len_reg);
		return longint'(node_pos[idx]);
	endfunction

	// Apply one command to the predictor and queue the basis beats it causes
	function automatic void predict_basis(nlbe_item_t it);
		longint p, lft, rgt, h, d;
		longint unsigned guess, wr, wl, g;
		int unsigned n, e;
		nlbe_result_t r;
		if (it.command == CMD_WRITE) begin
			if (it.node_index != 0) node_pos[it.node_index] = it.node_position;
			return;
		end
		p = longint'(it.point_position);
		if (p < 0 || p > longint'(domain_len_reg)) begin
			r = '0; r.out_of_domain = 1'b1; r.last = 1'b1;
			basis_q.insert(basis_q.size(), r);
			return;
		end
		n = (elem_count_reg == 0) ? 1 : (elem_count_reg > 1024) ? 1024 : elem_count_reg;
		guess = (longint'(p) * longint'({32'd0, inv_spacing_reg})) >> 32;
		e = (guess >= n - 1) ? n - 1 : int'(guess);
		if (e + 1 < n && p >= node_at(e + 1, n)) e = e + 1;
		else if (p >= node_at(e, n)) e = e;
		else if (e > 0) e = e - 1;
		lft = node_at(e, n);
		rgt = node_at(e + 1, n);
		h = rgt - lft;
		if (h <= 0) begin
			wr = 0; g = 0;
		end else begin
			d = p - lft;
			if (d <= 0) wr = 0;
			else if (d >= h) wr = 64'd65536;
			else wr = (longint'(d) << FRACTION_BITS) / h;
			g = (64'd1 << (2 * FRACTION_BITS)) / h;
			if (g > 64'h7FFF_FFFF) g = 64'h7FFF_FFFF;
		end
		wl = 64'd65536 - wr;
		r = '0;
		r.node_id = e[10:0]; r.weight = wl[16:0]; r.gradient = -signed'(g[31:0]);
		basis_q.insert(basis_q.size(), r);
		r.node_id = 11'(e + 1); r.weight = wr[16:0]; r.gradient = g[31:0]; r.last = 1'b1;
		basis_q.insert(basis_q.size(), r);
	endfunction

	function automatic nlbe_item_t eval_item(logic [31:0] pt);
		nlbe_item_t it;
		it = '0; it.command = CMD_EVAL; it.point_position = pt;
		it.node_index = 10'($urandom); it.node_position = 31'($urandom);
		return it;
	endfunction

	function automatic nlbe_item_t write_item(logic [9:0] idx, logic [30:0] pos);
		nlbe_item_t it;
		it = '0; it.command = CMD_WRITE; it.node_index = idx; it.node_position = pos;
		it.point_position = $urandom;
		return it;
	endfunction

	function automatic nlbe_result_t beat(logic [10:0] id, logic [16:0] w,
			logic [31:0] g, bit ood, bit lst);
		nlbe_result_t r;
		r.node_id = id; r.weight = w; r.gradient = g;
		r.out_of_domain = ood; r.last = lst;
		return r;
	endfunction

	// Hold valid and payload until the beat is taken
	task automatic send_item(nlbe_item_t it);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain_idle();
		item_valid <= 1'b0;
		while (basis_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_regs(logic [10:0] ec, logic [30:0] dl, logic [31:0] inv);
		cfg_write <= 1'b1; cfg_index <= CFG_ELEMENT_COUNT; cfg_data <= 32'(ec);
		@(posedge clk);
		cfg_index <= CFG_DOMAIN_LENGTH; cfg_data <= 32'(dl);
		@(posedge clk);
		cfg_index <= CFG_INVERSE_SPACING; cfg_data <= inv;
		@(posedge clk);
		cfg_write <= 1'b0;
		elem_count_reg = ec; domain_len_reg = dl; inv_spacing_reg = inv;
	endtask

	// Load an ordered node set spread over the domain
	task automatic load_nodes(int unsigned n);
		longint unsigned step, pos;
		nlbe_item_t it;
		step = longint'(domain_len_reg) / n;
		for (int unsigned i = 1; i < n; i++) begin
			pos = step * i;
			if (step > 4) pos = pos + $urandom_range(32'(step / 4), 0);
			it = write_item(10'(i), 31'(pos));
			predict_basis(it);
			send_item(it);
		end
	endtask

	// Receive side: check each beat, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (basis_q.size() == 0) begin
				$error("unexpected beat node_id %0d", result.node_id);
				failed = 1'b1;
			end else begin
				nlbe_result_t x;
				x = basis_q.pop_front();
				if (result.node_id !== x.node_id) begin
					$error("node_id exp %0d got %0d", x.node_id, result.node_id);
					failed = 1'b1;
				end
				if (result.weight !== x.weight) begin
					$error("weight exp %0d got %0d", x.weight, result.weight);
					failed = 1'b1;
				end
				if (result.gradient !== x.gradient) begin
					$error("gradient exp %0d got %0d", x.gradient, result.gradient);
					failed = 1'b1;
				end
				if (result.out_of_domain !== x.out_of_domain) begin
					$error("out_of_domain exp %0d got %0d", x.out_of_domain,
						result.out_of_domain);
					failed = 1'b1;
				end
				if (result.last !== x.last) begin
					$error("last exp %0d got %0d", x.last, result.last);
					failed = 1'b1;
				end
			end
		end
		result_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	typedef struct {
		nlbe_item_t   it;
		bit           typed;
		int           cnt;
		nlbe_result_t r0;
		nlbe_result_t r1;
	} stim_row_t;

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		logic [10:0] ph_ec  [NPHASE];
		logic [30:0] ph_dl  [NPHASE];
		logic [31:0] ph_inv [NPHASE];
		int unsigned n, k;
		longint unsigned q;
		logic [31:0] pt;
		nlbe_item_t it;

		ph_ec[0] = 11'd1024; ph_dl[0] = 31'd65536;       ph_inv[0] = 32'd67108864;
		ph_ec[1] = 11'd8;    ph_dl[1] = 31'h7FFF_FFFF;   ph_inv[1] = 0;
		ph_ec[2] = 11'd1;    ph_dl[2] = 31'd1;           ph_inv[2] = 32'hFFFF_FFFF;
		ph_ec[3] = 11'd0;    ph_dl[3] = 31'd1000;        ph_inv[3] = 32'd0;
		ph_ec[4] = 11'd200;  ph_dl[4] = 31'h0100_0000;   ph_inv[4] = 0;
		ph_ec[5] = 11'd37;   ph_dl[5] = 31'($urandom_range(32'h7FFF_FFFF, 5000));
		ph_inv[5] = $urandom;
		ph_ec[6] = 11'd16;   ph_dl[6] = 31'd200000;      ph_inv[6] = 0;

		failed = 1'b0; stall_cycles = 0;
		send_idle_pct = 35; recv_stall_pct = 56;
		cfg_write = 1'b0; cfg_index = CFG_ELEMENT_COUNT; cfg_data = '0;
		item_valid = 1'b0; item = '0; result_ready = 1'b0;
		elem_count_reg = ELEMENT_COUNT_RST;
		domain_len_reg = DOMAIN_LENGTH_RST;
		inv_spacing_reg = INVERSE_SPACING_RST;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Uniform nodes at reset values, node i at i/1024, near both ends only
		for (int i = 1; i < 1024; i++) begin
			if (i > 24 && i < 1000) continue;
			it = write_item(10'(i), 31'(i * 64));
			predict_basis(it);
			send_item(it);
		end

		// Directed table
		row.typed = 1'b1; row.cnt = 2;
		row.it = eval_item(32'd0);
		row.r0 = beat(11'd0, 17'd65536, -32'sd67108864, 1'b0, 1'b0);
		row.r1 = beat(11'd1, 17'd0, 32'd67108864, 1'b0, 1'b1);
		rows.insert(rows.size(), row);
		row.it = eval_item(32'd65536);
		row.r0 = beat(11'd1023, 17'd0, -32'sd67108864, 1'b0, 1'b0);
		row.r1 = beat(11'd1024, 17'd65536, 32'd67108864, 1'b0, 1'b1);
		rows.insert(rows.size(), row);
		row.cnt = 1;
		row.r0 = beat(11'd0, 17'd0, 32'd0, 1'b1, 1'b1);
		row.it = eval_item(32'hFFFF_FFFF); rows.insert(rows.size(), row);
		row.it = eval_item(32'h8000_0000); rows.insert(rows.size(), row);
		row.it = eval_item(32'd65537);     rows.insert(rows.size(), row);
		row.it = eval_item(32'h7FFF_FFFF); rows.insert(rows.size(), row);
		row.typed = 1'b0;
		row.it = eval_item(32'd64);         rows.insert(rows.size(), row);
		row.it = eval_item(32'd100);        rows.insert(rows.size(), row);
		row.it = eval_item(32'd1000);       rows.insert(rows.size(), row);
		row.it = write_item(10'd0, 31'd5);  rows.insert(rows.size(), row);
		row.it = eval_item(32'd3);          rows.insert(rows.size(), row);
		row.it = write_item(10'd5, 31'h7FFF_FFFF); rows.insert(rows.size(), row);
		row.it = eval_item(32'd330);        rows.insert(rows.size(), row);
		row.it = eval_item(32'd257);        rows.insert(rows.size(), row);
		row.it = write_item(10'd5, 31'd320); rows.insert(rows.size(), row);
		row.it = write_item(10'd10, 31'd576); rows.insert(rows.size(), row);
		row.it = eval_item(32'd576);        rows.insert(rows.size(), row);
		row.it = eval_item(32'd600);        rows.insert(rows.size(), row);
		row.it = write_item(10'd10, 31'd640); rows.insert(rows.size(), row);
		row.it = write_item(10'd1023, 31'd65535); rows.insert(rows.size(), row);
		row.it = eval_item(32'd65535);      rows.insert(rows.size(), row);
		row.it = write_item(10'd1023, 31'd65472); rows.insert(rows.size(), row);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				basis_q.insert(basis_q.size(), rows[i].r0);
				if (rows[i].cnt == 2) basis_q.insert(basis_q.size(), rows[i].r1);
			end else begin
				predict_basis(rows[i].it);
			end
			send_item(rows[i].it);
		end

		// Element count above the store clamps to the full grid
		drain_idle();
		write_regs(11'd2047, DOMAIN_LENGTH_RST, INVERSE_SPACING_RST);
		it = eval_item(32'd65536); predict_basis(it); send_item(it);
		it = eval_item(32'd65000); predict_basis(it); send_item(it);

		for (int ph = 1; ph < NPHASE; ph++) begin
			if (ph == 3) begin send_idle_pct = 56; recv_stall_pct = 35; end
			if (ph == 5) begin send_idle_pct = 0; recv_stall_pct = 0; end
			drain_idle();
			if (ph_inv[ph] == 0 && ph != 3) begin
				k = (ph_ec[ph] == 0) ? 1 : (ph_ec[ph] > 1024) ? 1024 : ph_ec[ph];
				q = (longint'(k) << 32) / ph_dl[ph];
				ph_inv[ph] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			end
			write_regs(ph_ec[ph], ph_dl[ph], ph_inv[ph]);
			n = (ph_ec[ph] == 0) ? 1 : (ph_ec[ph] > 1024) ? 1024 : ph_ec[ph];
			load_nodes(n);
			n = (elem_count_reg == 0) ? 1 : (elem_count_reg > 1024) ? 1024 : elem_count_reg;

			// Mostly in-domain points, some on nodes and edges, some noise
			for (int i = 0; i < RAND_ITEMS; i++) begin
				k = $urandom_range(99, 0);
				if (k < 40) begin
					it = eval_item($urandom_range(32'(domain_len_reg), 0));
				end else if (k < 60) begin
					case ($urandom_range(3, 0))
						0: pt = 32'(node_at($urandom_range(n, 0), n));
						1: pt = 32'(node_at($urandom_range(n, 0), n)) + 1;
						2: pt = 32'(node_at($urandom_range(n, 0), n)) - 1;
						default: pt = 32'(domain_len_reg);
					endcase
					it = eval_item(pt);
				end else if (k < 80) begin
					it = eval_item($urandom);
				end else if (k < 90) begin
					it = write_item(10'($urandom_range(n > 1 ? n - 1 : 1, 1)),
						31'($urandom_range(32'(domain_len_reg), 0)));
				end else begin
					it = write_item(10'($urandom), 31'($urandom));
					if (it.node_index >= n && it.node_index != 0) it.node_index = 0;
				end
				predict_basis(it);
				send_item(it);
			end
		end

		drain_idle();
		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/nlbe_pkg.sv
rtl/nlbe_front.sv
rtl/nlbe_queue.sv
rtl/nlbe_back.sv
rtl/nonuniform_linear_basis_eval.sv
rtl/nlbe_checker.sv
verif/tb_nonuniform_linear_basis_eval.sv
